// ===== rtl/core/olc_pkg.sv =====
// Shared types and constants for the oversampled level classifier.
// Used by olc_divider and oversampled_level_classifier; depends on nothing.
`timescale 1ns / 1ps

package olc_pkg;

    // Fixed field widths.
    localparam int ADC_BITS    = 12;
    localparam int FRAC_BITS   = 8;
    localparam int LEVEL_W     = ADC_BITS + FRAC_BITS;
    localparam int CNT_W       = 8;
    localparam int SUM_W       = ADC_BITS + CNT_W;
    localparam int WEIGHT_W    = 17;
    localparam int WEIGHT_FRAC = 16;
    localparam int TIME_W      = 32;
    localparam int CLASS_W     = 4;
    localparam int STABLE_W    = 16;
    localparam int TCOUNT_W    = 4;
    localparam int ENTRY_IDX_W = 3;

    localparam int MAX_TARGETS_DEF = 8;

    // Stream and register port widths.
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_FRAC);

    // Register reset values.
    localparam logic [CNT_W-1:0]    RST_OVERSAMPLE = CNT_W'(4);
    localparam logic                RST_FILTER_EN  = 1'b1;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT     = WEIGHT_W'(13107);
    localparam logic [ADC_BITS-1:0] RST_NO_OBJECT  = ADC_BITS'(100);
    localparam logic [ADC_BITS-1:0] RST_SATURATION = ADC_BITS'(4000);
    localparam logic [ADC_BITS-1:0] RST_HYSTERESIS = ADC_BITS'(20);
    localparam logic [STABLE_W-1:0] RST_MIN_STABLE = STABLE_W'(50);
    localparam logic [TCOUNT_W-1:0] RST_TCOUNT     = TCOUNT_W'(0);

    typedef enum logic [2:0] {
        REG_OVERSAMPLE = 3'd0,
        REG_FILTER_EN  = 3'd1,
        REG_WEIGHT     = 3'd2,
        REG_NO_OBJECT  = 3'd3,
        REG_SATURATION = 3'd4,
        REG_HYSTERESIS = 3'd5,
        REG_MIN_STABLE = 3'd6,
        REG_TCOUNT     = 3'd7
    } t_reg_idx;

    typedef enum logic {
        CMD_CONVERSION = 1'b0,
        CMD_ENTRY      = 1'b1
    } t_cmd;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DIV      = 8'b0000_0010,
        S_FILT_MUL = 8'b0000_0100,
        S_FILT_ADD = 8'b0000_1000,
        S_CUT      = 8'b0001_0000,
        S_CHK      = 8'b0010_0000,
        S_CMP      = 8'b0100_0000,
        S_COMMIT   = 8'b1000_0000
    } t_state;

endpackage

// ===== rtl/core/oversampled_level_classifier.sv =====
// Target writes and non-final conversions are taken in S_IDLE. A final conversion passes the
// bit-serial divider (S_DIV), the smoothing multiplier and adder (S_FILT_MUL, S_FILT_ADD), the
// cut-offs (S_CUT), a check and compare per used target (S_CHK, S_CMP) and S_COMMIT, which
// loads the output register. Smoothing drops out when off or not primed, and the walk when
// cut off or unused. Input is taken only in S_IDLE; S_COMMIT waits while the output stalls.
// Reset (synchronous, active low) loads register defaults; clears control, not data or table.
`timescale 1ns / 1ps

module oversampled_level_classifier
    import olc_pkg::*;
#(
    parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // adc_code[11:0], read_ok[12], time_ms[44:13], entry_index[47:45],
    // entry_low[59:48], entry_high[71:60], entry_class[75:72], zeros above
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // average_code[11:0], filtered_level[31:12], class_id[35:32],
    // class_stable[36], zeros above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int TCNT_W = $clog2(MAX_TARGETS + 1);
    localparam int PROD_W = LEVEL_W + WEIGHT_W + 2;

    // Configuration registers.
    logic [CNT_W-1:0]    r_oversample;
    logic                r_filter_en;
    logic [WEIGHT_W-1:0] r_weight;
    logic [ADC_BITS-1:0] r_no_object;
    logic [ADC_BITS-1:0] r_saturation;
    logic [ADC_BITS-1:0] r_hysteresis;
    logic [STABLE_W-1:0] r_min_stable;
    logic [TCOUNT_W-1:0] r_tcount;

    // Target table.
    logic [ADC_BITS-1:0] r_tlow   [MAX_TARGETS];
    logic [ADC_BITS-1:0] r_thigh  [MAX_TARGETS];
    logic [CLASS_W-1:0]  r_tclass [MAX_TARGETS];

    // Sequencer and state.
    t_state              r_state, n_state;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_seen;
    logic [CNT_W-1:0]    r_valid;
    logic [LEVEL_W-1:0]  r_smooth;
    logic                r_primed;
    logic [CLASS_W-1:0]  r_candidate;
    logic [TIME_W-1:0]   r_since;
    logic [CLASS_W-1:0]  r_committed;
    logic                r_stable;
    logic                r_out_valid;
    logic [TCNT_W-1:0]   r_idx;

    // Per-sample working registers.
    logic [TIME_W-1:0]        r_now;
    logic [ADC_BITS-1:0]      r_avg;
    logic [LEVEL_W-1:0]       r_level;
    logic signed [LEVEL_W:0]  r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_hit;
    logic [LEVEL_W-1:0]       r_dist;
    logic [CLASS_W-1:0]       r_ent_cls;
    logic                     r_found;
    logic [LEVEL_W-1:0]       r_best_dist;
    logic [CLASS_W-1:0]       r_cls;

    // Output register.
    logic [ADC_BITS-1:0] r_o_avg;
    logic [LEVEL_W-1:0]  r_o_level;
    logic [CLASS_W-1:0]  r_o_class;
    logic                r_o_stable;

    // Input fields.
    logic                   w_cmd;
    logic [ADC_BITS-1:0]    w_code;
    logic                   w_ok;
    logic [TIME_W-1:0]      w_time;
    logic [ENTRY_IDX_W-1:0] w_eidx;
    logic [ADC_BITS-1:0]    w_elow;
    logic [ADC_BITS-1:0]    w_ehigh;
    logic [CLASS_W-1:0]     w_ecls;

    logic                w_accept;
    logic                w_conv;
    logic [SUM_W-1:0]    w_sum_add;
    logic [CNT_W-1:0]    w_valid_add;
    logic [CNT_W-1:0]    w_seen_add;
    logic                w_sample_done;
    logic                w_div_done;
    logic [ADC_BITS-1:0] w_div_q;
    logic [LEVEL_W-1:0]  w_avg_level;
    logic [WEIGHT_W-1:0] w_weight_sat;
    logic signed [PROD_W-1:0] w_step;
    logic signed [PROD_W-1:0] w_filt_sum;
    logic [TCNT_W-1:0]   w_limit;
    logic [TCNT_W-1:0]   w_idx_next;
    logic                w_cut;

    logic [ADC_BITS-1:0]       w_ent_low;
    logic [ADC_BITS-1:0]       w_ent_high;
    logic [CLASS_W-1:0]        w_ent_cls;
    logic [ADC_BITS-1:0]       w_hy_eff;
    logic signed [ADC_BITS+1:0] w_lo_c;
    logic [ADC_BITS:0]         w_hi_c;
    logic                      w_below;
    logic                      w_above;
    logic [LEVEL_W-1:0]        w_center;
    logic [LEVEL_W-1:0]        w_dist;

    logic                w_cfg_wr;
    logic                w_out_free;
    logic [TIME_W-1:0]   w_elapsed;

    assign w_cmd   = s_axis_tuser[0];
    assign w_code  = s_axis_tdata[11:0];
    assign w_ok    = s_axis_tdata[12];
    assign w_time  = s_axis_tdata[44:13];
    assign w_eidx  = s_axis_tdata[47:45];
    assign w_elow  = s_axis_tdata[59:48];
    assign w_ehigh = s_axis_tdata[71:60];
    assign w_ecls  = s_axis_tdata[75:72];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_conv        = w_accept && (t_cmd'(w_cmd) == CMD_CONVERSION);

    assign w_sum_add   = r_sum + (w_ok ? SUM_W'(w_code) : SUM_W'(0));
    assign w_valid_add = r_valid + CNT_W'(w_ok);
    assign w_seen_add  = r_seen + 1'b1;
    // A zero count acts as one: the comparison is then always true.
    assign w_sample_done = w_conv && (w_seen_add >= r_oversample);

    olc_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sample_done),
        .i_dividend (w_sum_add),
        .i_divisor  (w_valid_add),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign w_avg_level  = {w_div_q, FRAC_BITS'(0)};
    assign w_weight_sat = (r_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_weight;

    // new = old + floor((w * (in - old) + half) / 2^16), equal to the blended form.
    assign w_step     = (r_prod + PROD_W'(1 << (WEIGHT_FRAC - 1))) >>> WEIGHT_FRAC;
    assign w_filt_sum = PROD_W'($signed({1'b0, r_smooth})) + w_step;

    assign w_limit    = (32'(r_tcount) > MAX_TARGETS) ? TCNT_W'(MAX_TARGETS)
                                                      : TCNT_W'(r_tcount);
    assign w_idx_next = r_idx + 1'b1;
    assign w_cut      = (r_level <= {r_no_object, FRAC_BITS'(0)}) ||
                        (r_level >= {r_saturation, FRAC_BITS'(0)});

    // Range test and distance to the center for the current table entry.
    assign w_ent_low  = r_tlow[r_idx[IDX_W-1:0]];
    assign w_ent_high = r_thigh[r_idx[IDX_W-1:0]];
    assign w_ent_cls  = r_tclass[r_idx[IDX_W-1:0]];
    assign w_hy_eff   = (w_ent_cls == r_committed) ? r_hysteresis : '0;
    assign w_lo_c     = $signed({2'b00, w_ent_low}) - $signed({2'b00, w_hy_eff});
    assign w_hi_c     = {1'b0, w_ent_high} + {1'b0, w_hy_eff};
    assign w_below    = $signed({2'b00, r_level}) < $signed({w_lo_c, FRAC_BITS'(0)});
    assign w_above    = {1'b0, r_level} > {w_hi_c, FRAC_BITS'(0)};
    assign w_center   = {({1'b0, w_ent_low} + {1'b0, w_ent_high}), (FRAC_BITS - 1)'(0)};
    assign w_dist     = (r_level >= w_center) ? (r_level - w_center) : (w_center - r_level);

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_elapsed  = r_now - r_since;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_sample_done) n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = (r_filter_en && r_primed) ? S_FILT_MUL : S_CUT;
                end
            end
            S_FILT_MUL: n_state = S_FILT_ADD;
            S_FILT_ADD: n_state = S_CUT;
            S_CUT: begin
                n_state = (w_cut || (w_limit == '0)) ? S_COMMIT : S_CHK;
            end
            S_CHK: n_state = S_CMP;
            S_CMP: begin
                n_state = (w_idx_next == w_limit) ? S_COMMIT : S_CHK;
            end
            S_COMMIT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_oversample <= RST_OVERSAMPLE;
            r_filter_en  <= RST_FILTER_EN;
            r_weight     <= RST_WEIGHT;
            r_no_object  <= RST_NO_OBJECT;
            r_saturation <= RST_SATURATION;
            r_hysteresis <= RST_HYSTERESIS;
            r_min_stable <= RST_MIN_STABLE;
            r_tcount     <= RST_TCOUNT;
            r_sum        <= '0;
            r_seen       <= '0;
            r_valid      <= '0;
            r_smooth     <= '0;
            r_primed     <= 1'b0;
            r_candidate  <= '0;
            r_since      <= '0;
            r_committed  <= '0;
            r_stable     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state <= n_state;

            if (w_cfg_wr) begin
                unique case (t_reg_idx'(paddr[4:2]))
                    REG_OVERSAMPLE: r_oversample <= pwdata[CNT_W-1:0];
                    REG_FILTER_EN:  r_filter_en  <= pwdata[0];
                    REG_WEIGHT:     r_weight     <= pwdata[WEIGHT_W-1:0];
                    REG_NO_OBJECT:  r_no_object  <= pwdata[ADC_BITS-1:0];
                    REG_SATURATION: r_saturation <= pwdata[ADC_BITS-1:0];
                    REG_HYSTERESIS: r_hysteresis <= pwdata[ADC_BITS-1:0];
                    REG_MIN_STABLE: r_min_stable <= pwdata[STABLE_W-1:0];
                    REG_TCOUNT:     r_tcount     <= pwdata[TCOUNT_W-1:0];
                    default: ;
                endcase
            end

            if (w_conv) begin
                if (w_sample_done) begin
                    r_sum   <= '0;
                    r_seen  <= '0;
                    r_valid <= '0;
                end else begin
                    r_sum   <= w_sum_add;
                    r_seen  <= w_seen_add;
                    r_valid <= w_valid_add;
                end
            end

            if ((r_state == S_COMMIT) && w_out_free) r_out_valid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_out_valid <= 1'b0;

            unique case (r_state)
                S_DIV: begin
                    if (w_div_done && r_filter_en && !r_primed) begin
                        r_smooth <= w_avg_level;
                        r_primed <= 1'b1;
                    end
                end
                S_FILT_ADD: r_smooth <= w_filt_sum[LEVEL_W-1:0];
                S_CUT:      r_idx    <= '0;
                S_CMP:      r_idx    <= w_idx_next;
                S_COMMIT: begin
                    if (w_out_free) begin
                        if (r_cls != r_candidate) begin
                            r_candidate <= r_cls;
                            r_since     <= r_now;
                            r_stable    <= 1'b0;
                        end else if (w_elapsed >= TIME_W'(r_min_stable)) begin
                            r_committed <= r_candidate;
                            r_stable    <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept && (t_cmd'(w_cmd) == CMD_ENTRY) && (32'(w_eidx) < MAX_TARGETS)) begin
            r_tlow[IDX_W'(w_eidx)]   <= w_elow;
            r_thigh[IDX_W'(w_eidx)]  <= w_ehigh;
            r_tclass[IDX_W'(w_eidx)] <= w_ecls;
        end

        if (w_sample_done) r_now <= w_time;

        case (r_state)
            S_DIV: begin
                if (w_div_done) begin
                    r_avg   <= w_div_q;
                    r_level <= w_avg_level;
                    r_diff  <= $signed({1'b0, w_avg_level}) - $signed({1'b0, r_smooth});
                end
            end
            S_FILT_MUL: r_prod <= $signed({1'b0, w_weight_sat}) * r_diff;
            S_FILT_ADD: r_level <= w_filt_sum[LEVEL_W-1:0];
            S_CUT: begin
                r_found <= 1'b0;
                r_cls   <= '0;
            end
            S_CHK: begin
                r_hit     <= !w_below && !w_above;
                r_dist    <= w_dist;
                r_ent_cls <= w_ent_cls;
            end
            S_CMP: begin
                // Strict compare keeps the lower index on a tie.
                if (r_hit && (!r_found || (r_dist < r_best_dist))) begin
                    r_found     <= 1'b1;
                    r_best_dist <= r_dist;
                    r_cls       <= r_ent_cls;
                end
            end
            default: ;
        endcase

        if ((r_state == S_COMMIT) && w_out_free) begin
            r_o_avg   <= r_avg;
            r_o_level <= r_level;
            if (r_cls != r_candidate) begin
                r_o_class  <= r_committed;
                r_o_stable <= 1'b0;
            end else if (w_elapsed >= TIME_W'(r_min_stable)) begin
                r_o_class  <= r_candidate;
                r_o_stable <= 1'b1;
            end else begin
                r_o_class  <= r_committed;
                r_o_stable <= r_stable;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - ADC_BITS - LEVEL_W - CLASS_W - 1)'(0),
                            r_o_stable, r_o_class, r_o_level, r_o_avg};

    assign pready = 1'b1;

    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_OVERSAMPLE: prdata = APB_DATA_W'(r_oversample);
            REG_FILTER_EN:  prdata = APB_DATA_W'(r_filter_en);
            REG_WEIGHT:     prdata = APB_DATA_W'(r_weight);
            REG_NO_OBJECT:  prdata = APB_DATA_W'(r_no_object);
            REG_SATURATION: prdata = APB_DATA_W'(r_saturation);
            REG_HYSTERESIS: prdata = APB_DATA_W'(r_hysteresis);
            REG_MIN_STABLE: prdata = APB_DATA_W'(r_min_stable);
            REG_TCOUNT:     prdata = APB_DATA_W'(r_tcount);
            default:        prdata = '0;
        endcase
    end

    // The divider finishes only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_valid_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid <= r_seen)
        else $error("valid conversion count exceeds conversions seen");

    a_sample_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sample_done |=> (r_state == S_DIV) && (r_seen == '0))
        else $error("completed sample did not start the divide");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_idx < w_limit))
        else $error("table walk index beyond used targets");

endmodule

// ===== rtl/core/olc_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the sample average.
// Depends on olc_pkg for the sum, count and code widths.
`timescale 1ns / 1ps

module olc_divider
    import olc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SUM_W-1:0]    i_dividend,
    input  logic [CNT_W-1:0]    i_divisor,
    output logic                o_done,
    output logic [ADC_BITS-1:0] o_quotient
);

    localparam int STEP_W = $clog2(ADC_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [CNT_W-1:0]    r_rem;
    logic [ADC_BITS-1:0] r_num;
    logic [ADC_BITS-1:0] r_q;
    logic [CNT_W-1:0]    r_divisor;
    logic                r_zero;

    logic [CNT_W:0]      w_trial;
    logic                w_fit;
    logic [CNT_W-1:0]    w_rem_next;

    // The sum never exceeds count * max code, so its upper bits are already
    // below the divisor and only ADC_BITS quotient bits remain to be found.
    assign w_trial    = {r_rem, r_num[ADC_BITS-1]};
    assign w_fit      = w_trial >= {1'b0, r_divisor};
    assign w_rem_next = w_fit ? CNT_W'(w_trial - {1'b0, r_divisor}) : CNT_W'(w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(ADC_BITS);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= i_dividend[SUM_W-1:ADC_BITS];
            r_num     <= i_dividend[ADC_BITS-1:0];
            r_divisor <= i_divisor;
            r_zero    <= (i_divisor == '0);
            r_q       <= '0;
        end else if (r_busy) begin
            r_rem <= w_rem_next;
            r_num <= {r_num[ADC_BITS-2:0], 1'b0};
            r_q   <= {r_q[ADC_BITS-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_zero ? '0 : r_q;

endmodule

// ===== dv/oversampled_level_classifier_test.sv =====
// Self-checking bench for oversampled_level_classifier: conversions and target writes go in on
// the stream port, settings on the register port, and each sample is checked against a model.
// Depends on olc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module oversampled_level_classifier_test;
    import olc_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 50;
    localparam int TABLE_SIZE    = 8;

    typedef struct {
        t_cmd      cmd;
        bit [11:0] adc_code;
        bit        read_ok;
        bit [31:0] stamp_ms;
        bit [2:0]  entry_index;
        bit [11:0] entry_low;
        bit [11:0] entry_high;
        bit [3:0]  entry_class;
    } t_level_req;

    typedef struct {
        bit [11:0] average_code;
        bit [19:0] filtered_level;
        bit [3:0]  class_id;
        bit        class_stable;
    } t_sample;

    class classifier_scoreboard;
        bit [7:0]        oversample;
        bit              smoothing_on;
        bit [16:0]       weight;
        bit [11:0]       no_object;
        bit [11:0]       saturation;
        bit [11:0]       hyst;
        bit [15:0]       min_stable;
        bit [3:0]        used_targets;

        int unsigned     code_sum;
        int unsigned     seen;
        int unsigned     valid;
        longint unsigned smooth;
        bit              primed;
        bit [3:0]        candidate;
        bit [31:0]       candidate_ms;
        bit [3:0]        committed;
        bit              stable;
        bit [11:0]       tgt_low [TABLE_SIZE];
        bit [11:0]       tgt_high [TABLE_SIZE];
        bit [3:0]        tgt_class [TABLE_SIZE];

        t_sample         expected_samples [$];
        int              errors;
        int              conversions;
        int              entry_writes;
        int              samples_checked;

        function new();
            oversample   = RST_OVERSAMPLE;
            smoothing_on = RST_FILTER_EN;
            weight       = RST_WEIGHT;
            no_object    = RST_NO_OBJECT;
            saturation   = RST_SATURATION;
            hyst         = RST_HYSTERESIS;
            min_stable   = RST_MIN_STABLE;
            used_targets = RST_TCOUNT;
        endfunction

        function void set_reg(t_reg_idx idx, bit [31:0] val);
            case (idx)
                REG_OVERSAMPLE: oversample   = val[7:0];
                REG_FILTER_EN:  smoothing_on = val[0];
                REG_WEIGHT:     weight       = val[16:0];
                REG_NO_OBJECT:  no_object    = val[11:0];
                REG_SATURATION: saturation   = val[11:0];
                REG_HYSTERESIS: hyst         = val[11:0];
                REG_MIN_STABLE: min_stable   = val[15:0];
                REG_TCOUNT:     used_targets = val[3:0];
            endcase
        endfunction

        // Targets holding the level compete on distance to their center; the
        // committed class gets its ranges widened by the hysteresis.
        function bit [3:0] nearest_target_class(longint unsigned lvl);
            int       n;
            int       i;
            bit [3:0] best;
            bit       found;
            longint   lv, lo, hi, center, span, best_span, widen;
            n = (used_targets > TABLE_SIZE) ? TABLE_SIZE : used_targets;
            best = 0;
            found = 0;
            best_span = 0;
            lv = lvl;
            widen = 64'(hyst) << FRAC_BITS;
            if (lvl <= (64'(no_object) << FRAC_BITS)) return 0;
            if (lvl >= (64'(saturation) << FRAC_BITS)) return 0;
            for (i = 0; i < n; i++) begin
                lo = 64'(tgt_low[i]) << FRAC_BITS;
                hi = 64'(tgt_high[i]) << FRAC_BITS;
                center = (64'(tgt_low[i]) + 64'(tgt_high[i])) << (FRAC_BITS - 1);
                if (tgt_class[i] == committed) begin
                    lo -= widen;
                    hi += widen;
                end
                if (lv < lo || lv > hi) continue;
                span = (lv >= center) ? lv - center : center - lv;
                if (!found || span < best_span) begin
                    found = 1;
                    best_span = span;
                    best = tgt_class[i];
                end
            end
            return best;
        endfunction

        function void note_request(t_level_req r);
            int unsigned     average;
            longint unsigned lvl;
            longint unsigned w;
            bit [3:0]        cls;
            bit [31:0]       held;
            t_sample         s;
            if (r.cmd == CMD_ENTRY) begin
                tgt_low[r.entry_index]   = r.entry_low;
                tgt_high[r.entry_index]  = r.entry_high;
                tgt_class[r.entry_index] = r.entry_class;
                entry_writes++;
                return;
            end
            conversions++;
            if (r.read_ok) begin
                code_sum += r.adc_code;
                valid++;
            end
            seen++;
            if (seen < oversample) return;

            average = (valid != 0) ? code_sum / valid : 0;
            code_sum = 0;
            seen = 0;
            valid = 0;
            lvl = 64'(average) << FRAC_BITS;
            if (smoothing_on) begin
                if (!primed) begin
                    smooth = lvl;
                    primed = 1;
                end else begin
                    w = (weight > 17'd65536) ? 65536 : weight;
                    smooth = (w * lvl + (65536 - w) * smooth + 32768) >> 16;
                end
                lvl = smooth;
            end

            cls = nearest_target_class(lvl);
            held = r.stamp_ms - candidate_ms;
            if (cls != candidate) begin
                candidate = cls;
                candidate_ms = r.stamp_ms;
                stable = 0;
            end else if (held >= min_stable) begin
                committed = candidate;
                stable = 1;
            end

            s.average_code   = average[11:0];
            s.filtered_level = lvl[19:0];
            s.class_id       = committed;
            s.class_stable   = stable;
            expected_samples.push_back(s);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_sample(bit [OUT_DATA_W-1:0] data);
            t_sample want;
            if (expected_samples.size() == 0) begin
                $display("%0t: sample %h arrived with nothing expected", $time, data);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            samples_checked++;
            compare("average_code", want.average_code, data[11:0]);
            compare("filtered_level", want.filtered_level, data[31:12]);
            compare("class_id", want.class_id, data[35:32]);
            compare("class_stable", want.class_stable, data[36]);
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bit                    steady_flow   = 1'b0;
    bit [31:0]             now_ms        = '0;
    bit [11:0]             focus_code    = 12'd400;
    int                    settings_used = 0;
    int                    quiet_cycles  = 0;
    classifier_scoreboard  sb            = new();

    oversampled_level_classifier DUT (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_sample(m_axis_tdata);
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: nothing accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_level_req random_fields(t_cmd cmd);
        t_level_req r;
        r.cmd         = cmd;
        r.adc_code    = 12'($urandom);
        r.read_ok     = 1'($urandom);
        r.stamp_ms    = $urandom;
        r.entry_index = 3'($urandom);
        r.entry_low   = 12'($urandom);
        r.entry_high  = 12'($urandom);
        r.entry_class = 4'($urandom);
        return r;
    endfunction

    // valid stays high from one request to the next unless an idle gap falls between them.
    task automatic send_request(input t_level_req r);
        int gap;
        gap = 0;
        while (!steady_flow && $urandom_range(0, 99) < 16) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {4'b0, r.entry_class, r.entry_high, r.entry_low, r.entry_index,
                          r.stamp_ms, r.read_ok, r.adc_code};
        s_axis_tuser  <= r.cmd;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic send_conversion(input bit [11:0] code, input bit ok, input int unsigned step);
        t_level_req r;
        r = random_fields(CMD_CONVERSION);
        now_ms += step;
        r.adc_code = code;
        r.read_ok  = ok;
        r.stamp_ms = now_ms;
        send_request(r);
    endtask

    task automatic send_entry(input bit [2:0] idx, input bit [11:0] lo, input bit [11:0] hi,
                              input bit [3:0] cls);
        t_level_req r;
        r = random_fields(CMD_ENTRY);
        r.entry_index = idx;
        r.entry_low   = lo;
        r.entry_high  = hi;
        r.entry_class = cls;
        send_request(r);
    endtask

    // Stops the stream until every sample is back and the block has had time to go idle.
    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input bit [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_settings(input bit [7:0] ovs, input bit fen, input bit [16:0] wgt,
                                  input bit [11:0] nob, input bit [11:0] sat,
                                  input bit [11:0] hys, input bit [15:0] mst,
                                  input bit [3:0] tcnt);
        drain_stream();
        write_reg(REG_OVERSAMPLE, 32'(ovs));
        write_reg(REG_FILTER_EN, 32'(fen));
        write_reg(REG_WEIGHT, 32'(wgt));
        write_reg(REG_NO_OBJECT, 32'(nob));
        write_reg(REG_SATURATION, 32'(sat));
        write_reg(REG_HYSTERESIS, 32'(hys));
        write_reg(REG_MIN_STABLE, 32'(mst));
        write_reg(REG_TCOUNT, 32'(tcnt));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    task automatic random_settings();
        bit [16:0] wgt;
        bit [11:0] nob, sat, hys;
        bit [15:0] mst;
        bit [3:0]  tcnt;
        case ($urandom_range(0, 4))
            0:       wgt = 17'd0;
            1:       wgt = 17'd65536;
            2:       wgt = 17'($urandom_range(65537, 131071));
            default: wgt = 17'($urandom_range(3000, 50000));
        endcase
        nob  = ($urandom_range(0, 9) == 0) ? 12'd4095 : 12'($urandom_range(0, 300));
        sat  = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(3700, 4095));
        hys  = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 80));
        mst  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120));
        tcnt = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd8;
        apply_settings(8'($urandom_range(0, 6)), $urandom_range(0, 3) != 0, wgt, nob, sat,
                       hys, mst, tcnt);
    endtask

    // Conversions cluster around a slowly moving level so classes get the chance to settle
    // and commit; a share of wild codes, failed reads, time jumps and table rewrites mixes in.
    task automatic random_item();
        t_level_req  r;
        int          code;
        int unsigned step;
        if ($urandom_range(0, 99) < 6) begin
            r = random_fields(CMD_ENTRY);
            if ($urandom_range(0, 1) != 0)
                r.entry_high = (r.entry_low > 12'd3600) ? 12'hFFF
                                                        : r.entry_low + 12'($urandom_range(0, 500));
            send_request(r);
        end else begin
            if ($urandom_range(0, 99) < 10) focus_code = 12'($urandom);
            code = int'(focus_code) - 15 + int'($urandom_range(0, 30));
            if (code < 0) code = 0;
            if (code > 4095) code = 4095;
            if ($urandom_range(0, 99) < 10) code = int'($urandom_range(0, 4095));
            step = ($urandom_range(0, 99) < 3) ? $urandom_range(0, 100000) : $urandom_range(0, 20);
            if ($urandom_range(0, 99) == 0) now_ms = $urandom;
            send_conversion(12'(code), $urandom_range(0, 99) >= 10, step);
        end
    endtask

    initial begin
        int n;
        int start_count;
        int phase_conversions;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The whole table is loaded while no target is in use, so no lookup ever
        // touches a slot that was never written.
        send_entry(3'd0, 12'd200, 12'd600, 4'd1);
        send_entry(3'd1, 12'd500, 12'd900, 4'd2);
        send_entry(3'd2, 12'd1000, 12'd1000, 4'd15);
        send_entry(3'd3, 12'd1500, 12'd1400, 4'd3);
        send_entry(3'd4, 12'd2000, 12'd2400, 4'd4);
        send_entry(3'd5, 12'd2000, 12'd2400, 4'd5);
        send_entry(3'd6, 12'd0, 12'd4095, 4'd6);
        send_entry(3'd7, 12'd3000, 12'd3500, 4'd7);

        apply_settings(8'd1, 1'b0, 17'd65536, 12'd100, 12'd4000, 12'd20, 16'd0, 4'd8);
        now_ms = 32'hFFFF_FFF0;
        send_conversion(12'd0, 1'b1, 5);
        send_conversion(12'd4095, 1'b1, 5);
        send_conversion(12'd1234, 1'b0, 5);
        send_conversion(12'd100, 1'b1, 5);
        send_conversion(12'd4000, 1'b1, 5);
        send_conversion(12'd400, 1'b1, 5);
        send_conversion(12'd400, 1'b1, 5);
        send_conversion(12'd560, 1'b1, 5);
        send_conversion(12'd560, 1'b1, 5);
        send_conversion(12'd1000, 1'b1, 5);
        send_conversion(12'd1450, 1'b1, 5);
        send_conversion(12'd2200, 1'b1, 5);
        send_conversion(12'd2200, 1'b1, 5);
        send_conversion(12'd3200, 1'b1, 5);
        send_conversion(12'd3200, 1'b1, 5);

        for (n = 0; n < 8; n++) begin
            case (n)
                0:       apply_settings(8'd0, 1'b1, 17'd0, 12'd0, 12'd4095, 12'd0, 16'd0, 4'd8);
                1:       apply_settings(8'd255, 1'b1, 17'd40000, 12'd100, 12'd4000, 12'd30,
                                        16'd20, 4'd8);
                3:       apply_settings(8'd2, 1'b1, 17'd131071, 12'd0, 12'd4095, 12'd4095,
                                        16'd65535, 4'd15);
                default: random_settings();
            endcase
            steady_flow <= (n == 5);
            // The longest sample setting runs a little past one full sample so the next,
            // smaller count finds more conversions already gathered than it asks for.
            phase_conversions = (n == 1) ? 265 : 26;
            start_count = sb.conversions;
            while (sb.conversions - start_count < phase_conversions) begin
                if (sb.conversions - start_count == phase_conversions / 2 &&
                    $urandom_range(0, 1) != 0)
                    drain_stream();
                random_item();
            end
        end
        steady_flow <= 1'b0;
        drain_stream();

        $display("Covered %0d conversions and %0d table writes under %0d register settings,",
                 sb.conversions, sb.entry_writes, settings_used);
        $display("with %0d samples compared field by field.", sb.samples_checked);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/olc_pkg.sv
rtl/core/olc_divider.sv
rtl/core/oversampled_level_classifier.sv
dv/oversampled_level_classifier_test.sv
